// File: rtl/carp_pkg.sv
// ---------------------------------------------------------------------------
// carp_pkg
// constants and register indexes for the cascaded angle/rate pid unit
// ---------------------------------------------------------------------------
package carp_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_ANGLE_GAIN    = 3'd0;
  localparam logic [2:0] CFG_RATE_P_GAIN   = 3'd1;
  localparam logic [2:0] CFG_RATE_I_GAIN   = 3'd2;
  localparam logic [2:0] CFG_RATE_D_GAIN   = 3'd3;
  localparam logic [2:0] CFG_INTEGRAL_LOW  = 3'd4;
  localparam logic [2:0] CFG_INTEGRAL_HIGH = 3'd5;
  localparam logic [2:0] CFG_DERIV_TAU     = 3'd6;

  // register reset values
  localparam logic [31:0] INTEGRAL_LOW_RST  = 32'hF666_6666;
  localparam logic [31:0] INTEGRAL_HIGH_RST = 32'h0999_999A;
  localparam logic [19:0] DERIV_TAU_RST     = 20'd5000;

  // step time window in microseconds
  localparam logic [15:0] DT_MIN_US = 16'd500;
  localparam logic [15:0] DT_MAX_US = 16'd50000;

  // limits
  localparam logic [20:0] ANGLE_ERR_LIM  = 21'd1966080;
  localparam logic [23:0] RATE_DES_LIM   = 24'd9830400;
  localparam logic [23:0] RATE_DELTA_LIM = 24'd13107200;
  localparam logic [28:0] DRIVE_LIM      = 29'd322122547;
  localparam logic [48:0] P_CAP          = 49'h1_0000_0000_0000;
  localparam logic [33:0] INC_CAP        = 34'h2_0000_0000;
  localparam logic [47:0] D_NEG_MAX      = 48'h8000_0000_0000;
  localparam logic [47:0] D_POS_MAX      = 48'h7FFF_FFFF_FFFF;

  // scaling
  localparam logic [21:0] I_DIVISOR = 22'd4000000;
  localparam logic [31:0] D_SCALE   = 32'd250000;
  localparam logic [63:0] Q16_ROUND = 64'd32768;

  // bit-serial divider
  localparam int unsigned ACC_W  = 80;
  localparam int unsigned DIVR_W = 22;
  localparam logic [6:0]  DIV_LAST = 7'd79;

endpackage

// File: rtl/cascaded_angle_rate_pid_unit.sv
// ---------------------------------------------------------------------------
// cascaded_angle_rate_pid_unit
// one-axis cascaded angle/rate pid with integrator, filtered derivative
// and clamped drive, fixed point throughout
// ---------------------------------------------------------------------------
// sequencing: one shared bit-serial divider runs up to three times per word
//   (integrator, derivative, filter); the derivative divide is skipped when
//   the derivative saturates
// throughput: one word at a time; in_ready only in idle
// reset: synchronous active-high rst restores register defaults and clears
//   integrator, last rate and derivative store
// ---------------------------------------------------------------------------
module cascaded_angle_rate_pid_unit (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target_angle,
  input  logic [31:0] measured_angle,
  input  logic [31:0] measured_rate,
  input  logic [15:0] step_time_us,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] drive,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned ACC_W_L  = carp_pkg::ACC_W;
  localparam int unsigned DIVR_W_L = carp_pkg::DIVR_W;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_PREP2, S_OUT_MUL, S_RATE_DES, S_RE, S_RE_MAG,
    S_P_MUL, S_P_TERM, S_I_MUL, S_W_LOAD, S_W_LO, S_W_HI, S_W_ADD,
    S_DIV, S_I_DONE, S_I_CLAMP, S_D_MUL, S_D_CHECK, S_D_DONE,
    S_F_SETUP, S_F_MAG, S_F_DONE, S_SUM
  } state_t;

  // which term the shared wide multiply and divide is serving
  typedef enum logic [1:0] {PH_I, PH_D, PH_F} phase_t;

  state_t state;
  phase_t phase;

  // configuration registers
  logic [31:0] angle_gain, rate_p_gain, rate_i_gain, rate_d_gain;
  logic [31:0] integral_low, integral_high;
  logic [19:0] deriv_tau;

  // controller state
  logic [31:0] integral_sum;
  logic [31:0] last_rate;
  logic [47:0] deriv_filtered;

  // latched input word
  logic [31:0] tgt, meas, rate_in;
  logic [15:0] dt;

  // working registers
  logic [32:0] ediff, drdiff;
  logic        e_neg, dr_pos;
  logic [20:0] e_mag;
  logic [23:0] dr_mag;
  logic [63:0] prod;
  logic [24:0] rdes;
  logic [32:0] re;
  logic        re_neg;
  logic [31:0] re_mag;
  logic [49:0] up;
  logic [34:0] isum_tmp;
  logic [47:0] raw;
  logic [48:0] diff;
  logic        diff_neg;
  logic [47:0] diff_mag;
  logic [63:0] wide;
  logic [DIVR_W_L-1:0] div_d;
  logic [ACC_W_L-1:0]  acc;
  logic [DIVR_W_L-1:0] rem;
  logic [6:0]  cnt;

  // ---- shared 32x32 multiplier, operands picked by state ----
  logic [31:0] mul_a, mul_b, w_small;
  logic [63:0] mul_p;

  always_comb begin
    w_small = (phase == PH_D) ? carp_pkg::D_SCALE : {16'b0, dt};
    case (state)
      S_OUT_MUL: begin
        mul_a = angle_gain;
        mul_b = {11'b0, e_mag};
      end
      S_P_MUL: begin
        mul_a = rate_p_gain;
        mul_b = re_mag;
      end
      S_I_MUL: begin
        mul_a = rate_i_gain;
        mul_b = re_mag;
      end
      S_D_MUL: begin
        mul_a = rate_d_gain;
        mul_b = {8'b0, dr_mag};
      end
      S_W_LO: begin
        mul_a = wide[31:0];
        mul_b = w_small;
      end
      S_W_HI: begin
        mul_a = wide[63:32];
        mul_b = w_small;
      end
      default: begin
        mul_a = 32'b0;
        mul_b = 32'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---- input clamps ----
  logic [15:0] dt_clamped;
  logic [32:0] eabs, drabs;

  always_comb begin
    if (step_time_us < carp_pkg::DT_MIN_US) begin
      dt_clamped = carp_pkg::DT_MIN_US;
    end else if (step_time_us > carp_pkg::DT_MAX_US) begin
      dt_clamped = carp_pkg::DT_MAX_US;
    end else begin
      dt_clamped = step_time_us;
    end
    eabs  = ediff[32] ? -ediff : ediff;
    drabs = drdiff[32] ? -drdiff : drdiff;
  end

  // ---- outer loop and proportional term ----
  logic [63:0] rd_m;
  logic [23:0] rd_cap;
  logic [64:0] p_m;
  logic [48:0] p_cap;

  always_comb begin
    rd_m   = (prod + carp_pkg::Q16_ROUND) >> 16;
    rd_cap = (rd_m > 64'(carp_pkg::RATE_DES_LIM)) ? carp_pkg::RATE_DES_LIM : rd_m[23:0];
    p_m    = ({1'b0, prod} + 65'd2) >> 2;
    p_cap  = (p_m > 65'(carp_pkg::P_CAP)) ? carp_pkg::P_CAP : p_m[48:0];
  end

  // ---- integrator ----
  logic [33:0] i_cap;
  logic [34:0] inc, hi35, lo35, i_t;

  always_comb begin
    i_cap = (acc > ACC_W_L'(carp_pkg::INC_CAP)) ? carp_pkg::INC_CAP : acc[33:0];
    inc   = re_neg ? -{1'b0, i_cap} : {1'b0, i_cap};
    hi35  = {{3{integral_high[31]}}, integral_high};
    lo35  = {{3{integral_low[31]}}, integral_low};
    // upper bound first, lower bound wins when the two cross
    i_t   = ($signed(isum_tmp) > $signed(hi35)) ? hi35 : isum_tmp;
  end

  // ---- derivative ----
  logic [55:0] d_thr;
  logic [47:0] d_cap_neg, d_cap_pos;
  logic [49:0] f_sum;
  logic [47:0] f_m;

  always_comb begin
    // p / dt > 2^40 exactly when p >= (2^40 + 1) * dt
    d_thr     = {dt, 40'b0} + {40'b0, dt};
    d_cap_neg = (acc > ACC_W_L'(carp_pkg::D_NEG_MAX)) ? carp_pkg::D_NEG_MAX : acc[47:0];
    d_cap_pos = (acc > ACC_W_L'(carp_pkg::D_POS_MAX)) ? carp_pkg::D_POS_MAX : acc[47:0];
    f_m       = acc[47:0];
    f_sum     = {{2{deriv_filtered[47]}}, deriv_filtered}
              + (diff_neg ? -{2'b0, f_m} : {2'b0, f_m});
  end

  // ---- output sum ----
  logic [51:0] s_sum;
  logic [51:0] s_lim_p, s_lim_n;
  logic [51:0] s_clamped;

  always_comb begin
    s_sum   = {{2{up[49]}}, up} + {{20{integral_sum[31]}}, integral_sum}
            + {{4{deriv_filtered[47]}}, deriv_filtered};
    s_lim_p = {23'b0, carp_pkg::DRIVE_LIM};
    s_lim_n = -s_lim_p;
    if ($signed(s_sum) > $signed(s_lim_p)) begin
      s_clamped = s_lim_p;
    end else if ($signed(s_sum) < $signed(s_lim_n)) begin
      s_clamped = s_lim_n;
    end else begin
      s_clamped = s_sum;
    end
  end

  // ---- divider step ----
  logic [DIVR_W_L:0] trial;
  logic              q_bit;

  always_comb begin
    trial = {rem, acc[ACC_W_L-1]};
    q_bit = (trial >= {1'b0, div_d});
  end

  assign in_ready = (state == S_IDLE);

  // ---- sequencer, datapath and registered outputs ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_I;
      out_valid      <= 1'b0;
      angle_gain     <= 32'b0;
      rate_p_gain    <= 32'b0;
      rate_i_gain    <= 32'b0;
      rate_d_gain    <= 32'b0;
      integral_low   <= carp_pkg::INTEGRAL_LOW_RST;
      integral_high  <= carp_pkg::INTEGRAL_HIGH_RST;
      deriv_tau      <= carp_pkg::DERIV_TAU_RST;
      integral_sum   <= 32'b0;
      last_rate      <= 32'b0;
      deriv_filtered <= 48'b0;
      cnt            <= 7'b0;
    end else begin
      // configuration writes, out-of-range index ignored
      if (cfg_we) begin
        case (cfg_index)
          carp_pkg::CFG_ANGLE_GAIN:    angle_gain    <= cfg_data;
          carp_pkg::CFG_RATE_P_GAIN:   rate_p_gain   <= cfg_data;
          carp_pkg::CFG_RATE_I_GAIN:   rate_i_gain   <= cfg_data;
          carp_pkg::CFG_RATE_D_GAIN:   rate_d_gain   <= cfg_data;
          carp_pkg::CFG_INTEGRAL_LOW:  integral_low  <= cfg_data;
          carp_pkg::CFG_INTEGRAL_HIGH: integral_high <= cfg_data;
          carp_pkg::CFG_DERIV_TAU:     deriv_tau     <= cfg_data[19:0];
          default: ;
        endcase
      end

      // in the final state a taken word is replaced by the next one
      if (out_valid && out_ready && state != S_SUM) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt     <= target_angle;
            meas    <= measured_angle;
            rate_in <= measured_rate;
            dt      <= dt_clamped;
            state   <= S_PREP;
          end
        end
        // raw angle error and rate change
        S_PREP: begin
          ediff     <= {tgt[31], tgt} - {meas[31], meas};
          drdiff    <= {rate_in[31], rate_in} - {last_rate[31], last_rate};
          last_rate <= rate_in;
          state     <= S_PREP2;
        end
        // sign and clamped magnitude of both
        S_PREP2: begin
          e_neg  <= ediff[32];
          e_mag  <= (eabs > 33'(carp_pkg::ANGLE_ERR_LIM)) ? carp_pkg::ANGLE_ERR_LIM
                                                           : eabs[20:0];
          dr_pos <= !drdiff[32] && (drdiff != 33'b0);
          dr_mag <= (drabs > 33'(carp_pkg::RATE_DELTA_LIM)) ? carp_pkg::RATE_DELTA_LIM
                                                             : drabs[23:0];
          state  <= S_OUT_MUL;
        end
        S_OUT_MUL: begin
          prod  <= mul_p;
          state <= S_RATE_DES;
        end
        // rate demand, rounded and clamped
        S_RATE_DES: begin
          rdes  <= e_neg ? -{1'b0, rd_cap} : {1'b0, rd_cap};
          state <= S_RE;
        end
        S_RE: begin
          re    <= {{8{rdes[24]}}, rdes} - {rate_in[31], rate_in};
          state <= S_RE_MAG;
        end
        S_RE_MAG: begin
          re_neg <= re[32];
          re_mag <= re[32] ? 32'(-re) : re[31:0];
          state  <= S_P_MUL;
        end
        S_P_MUL: begin
          prod  <= mul_p;
          state <= S_P_TERM;
        end
        S_P_TERM: begin
          up    <= re_neg ? -{1'b0, p_cap} : {1'b0, p_cap};
          state <= S_I_MUL;
        end
        S_I_MUL: begin
          prod  <= mul_p;
          phase <= PH_I;
          state <= S_W_LOAD;
        end
        // wide multiply by a 16 or 18 bit factor, then rounded divide
        S_W_LOAD: begin
          wide <= (phase == PH_F) ? {16'b0, diff_mag} : prod;
          case (phase)
            PH_I:    div_d <= carp_pkg::I_DIVISOR;
            PH_D:    div_d <= {6'b0, dt};
            PH_F:    div_d <= {6'b0, dt} + {2'b0, deriv_tau};
            default: div_d <= carp_pkg::I_DIVISOR;
          endcase
          state <= S_W_LO;
        end
        S_W_LO: begin
          prod  <= mul_p;
          state <= S_W_HI;
        end
        S_W_HI: begin
          // half the divisor added for round to nearest
          acc   <= {16'b0, prod} + {58'b0, 1'b0, div_d[DIVR_W_L-1:1]};
          prod  <= mul_p;
          state <= S_W_ADD;
        end
        S_W_ADD: begin
          acc   <= acc + {prod[47:0], 32'b0};
          rem   <= '0;
          cnt   <= 7'b0;
          state <= S_DIV;
        end
        // restoring divide, one quotient bit a cycle
        S_DIV: begin
          rem <= q_bit ? DIVR_W_L'(trial - {1'b0, div_d}) : trial[DIVR_W_L-1:0];
          acc <= {acc[ACC_W_L-2:0], q_bit};
          cnt <= cnt + 7'd1;
          if (cnt == carp_pkg::DIV_LAST) begin
            case (phase)
              PH_I:    state <= S_I_DONE;
              PH_D:    state <= S_D_DONE;
              PH_F:    state <= S_F_DONE;
              default: state <= S_I_DONE;
            endcase
          end
        end
        S_I_DONE: begin
          isum_tmp <= {{3{integral_sum[31]}}, integral_sum} + inc;
          state    <= S_I_CLAMP;
        end
        S_I_CLAMP: begin
          integral_sum <= ($signed(i_t) < $signed(lo35)) ? integral_low : i_t[31:0];
          state        <= S_D_MUL;
        end
        S_D_MUL: begin
          prod  <= mul_p;
          state <= S_D_CHECK;
        end
        // quotient far beyond the store: saturate without dividing
        S_D_CHECK: begin
          if (prod >= {8'b0, d_thr}) begin
            raw   <= dr_pos ? carp_pkg::D_NEG_MAX : carp_pkg::D_POS_MAX;
            state <= S_F_SETUP;
          end else begin
            phase <= PH_D;
            state <= S_W_LOAD;
          end
        end
        S_D_DONE: begin
          raw   <= dr_pos ? -d_cap_neg : d_cap_pos;
          state <= S_F_SETUP;
        end
        S_F_SETUP: begin
          diff  <= {raw[47], raw} - {deriv_filtered[47], deriv_filtered};
          state <= S_F_MAG;
        end
        S_F_MAG: begin
          diff_neg <= diff[48];
          diff_mag <= diff[48] ? 48'(-diff) : diff[47:0];
          phase    <= PH_F;
          state    <= S_W_LOAD;
        end
        // low-pass update with 48 bit saturation
        S_F_DONE: begin
          if ($signed(f_sum) > $signed({2'b0, carp_pkg::D_POS_MAX})) begin
            deriv_filtered <= carp_pkg::D_POS_MAX;
          end else if ($signed(f_sum) < $signed({2'b11, carp_pkg::D_NEG_MAX})) begin
            deriv_filtered <= carp_pkg::D_NEG_MAX;
          end else begin
            deriv_filtered <= f_sum[47:0];
          end
          state <= S_SUM;
        end
        // hold here until the previous word has been taken
        S_SUM: begin
          if (!out_valid || out_ready) begin
            drive     <= s_clamped[29:0];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // drive never leaves the clamp window
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(drive) <= $signed({1'b0, carp_pkg::DRIVE_LIM})
                && $signed(drive) >= -$signed({1'b0, carp_pkg::DRIVE_LIM})))
    else $error("drive outside clamp window");

  // divider remainder always below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < div_d))
    else $error("divider remainder not below divisor");

  // integrator lands inside ordered bounds
  a_int_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_I_CLAMP && $signed(integral_low) <= $signed(integral_high))
    |=> ($signed(integral_sum) >= $signed(integral_low)
      && $signed(integral_sum) <= $signed(integral_high)))
    else $error("integrator outside bounds");

  // one word at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");
`endif

endmodule
